// ===== design/nlej_pkg.sv =====
// Package for the nested-loop equi-join probe block.
// Holds the item kind codes and the result structs shared by the control
// module and the top level. Depends on nothing.
package nlej_pkg;

  localparam int unsigned KeyW      = 64;
  localparam int unsigned RowW      = 16;
  localparam int unsigned BuildIdxW = 6;
  localparam int unsigned KindW     = 2;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_PROBE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic                 store_overflowed;
    logic                 last_match;
    logic [BuildIdxW-1:0] match_build_index;
    logic [RowW-1:0]      match_probe_row;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

// ===== design/nlej_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while the read enable is low. Depends on nothing.
module nlej_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nlej_ctrl.sv =====
// Control for the join probe: build store bookkeeping and the probe scan.
// Drives the key RAM (nlej_ram) and hands results to the output stage.
// Depends on nlej_pkg.
module nlej_ctrl #(
  parameter int unsigned BUILD_DEPTH = 64,
  localparam int unsigned AW = (BUILD_DEPTH > 1) ? $clog2(BUILD_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nlej_pkg::kind_e               in_kind_i,
  input  logic [nlej_pkg::KeyW-1:0]     in_key_i,
  input  logic                          in_null_i,
  input  logic [nlej_pkg::RowW-1:0]     in_row_i,
  input  logic                          out_free_i,
  output nlej_pkg::push_t               push_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [nlej_pkg::KeyW-1:0]     ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [nlej_pkg::KeyW-1:0]     ram_rdata_i
);
  import nlej_pkg::*;

  localparam int unsigned CW = $clog2(BUILD_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            pend_valid_q, pend_valid_d;
  logic [AW-1:0]   pend_q, pend_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [RowW-1:0] row_q, row_d;
  logic            is_match;
  logic            is_last;
  logic            stall;

  // The RAM output word belongs to entry idx_q whenever the scan is running.
  assign is_match = (ram_rdata_i == key_q);
  assign is_last  = ((CW'(idx_q) + CW'(1)) == count_q);
  assign stall    = is_match && pend_valid_q && !out_free_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign ram_waddr_o = AW'(count_q);
  assign ram_wdata_o = in_key_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    idx_d        = idx_q;
    key_d        = key_q;
    row_d        = row_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = idx_q + AW'(1);
    push_o.valid                 = 1'b0;
    push_o.res.match_probe_row   = row_q;
    push_o.res.match_build_index = BuildIdxW'(pend_q);
    push_o.res.last_match        = 1'b0;
    push_o.res.store_overflowed  = ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            KIND_BUILD: begin
              if (!in_null_i) begin
                if (count_q == CW'(BUILD_DEPTH)) begin
                  ovf_d = 1'b1;
                end else begin
                  ram_we_o = 1'b1;
                  count_d  = count_q + CW'(1);
                end
              end
            end
            KIND_PROBE: begin
              if (!in_null_i && (count_q != '0)) begin
                ram_re_o     = 1'b1;
                ram_raddr_o  = '0;
                idx_d        = '0;
                key_d        = in_key_i;
                row_d        = in_row_i;
                pend_valid_d = 1'b0;
                state_d      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // A match is held back one step so that the final one can carry tlast.
        if (!stall) begin
          if (is_match) begin
            push_o.valid = pend_valid_q;
            pend_d       = idx_q;
            pend_valid_d = 1'b1;
          end
          if (is_last) begin
            state_d = ST_FLUSH;
          end else begin
            ram_re_o = 1'b1;
            idx_d    = idx_q + AW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          push_o.valid          = 1'b1;
          push_o.res.last_match = 1'b1;
          pend_valid_d          = 1'b0;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    row_q  <= row_d;
  end

endmodule

// ===== design/nested_loop_equi_join_probe_top.sv =====
// Top level of the nested-loop equi-join probe block.
// Ties the key RAM and the control together and holds the output register.
// Depends on nlej_pkg, nlej_ram and nlej_ctrl.
//
// Input beats on the s_axis channel carry one item: tuser selects clear,
// build or probe and flags a null key; tdata holds the key and probe row.
// A clear empties the key store and drops the overflow flag. A build beat
// appends its key unless it is null; once BUILD_DEPTH keys are held further
// keys are dropped and the sticky overflow flag is set.
// A probe beat reads the stored keys from the key RAM one per cycle unless
// the receiver stalls, and the block takes no new beat until the probe is
// done; clear and build beats are accepted back to back. Every equal
// key gives one m_axis beat in ascending build index, and the final one of a
// probe has tlast set. A match is held until the next one is found or the
// scan ends.
// When m_axis_tready is low the scan pauses at a further match while the
// output register and the held match are both occupied; nothing is lost.
// s_axis_tready is low while a probe is in progress.
// Reset empties the store and clears the flag; no RAM clearing is needed.
module nested_loop_equi_join_probe_top #(
  parameter int unsigned BUILD_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] key_value, [79:64] probe_row
  input  logic [79:0] s_axis_tdata,
  // [1:0] kind, [2] key_is_null
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] match_probe_row, [21:16] match_build_index, [22] store_overflowed,
  // [23] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import nlej_pkg::*;

  localparam int unsigned AW = (BUILD_DEPTH > 1) ? $clog2(BUILD_DEPTH) : 1;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [KeyW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [KeyW-1:0] ram_rdata;
  logic            out_free;
  push_t           push;
  logic            out_valid_q;
  result_t         out_q;

  nlej_ram #(
    .WIDTH (KeyW),
    .DEPTH (BUILD_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nlej_ctrl #(
    .BUILD_DEPTH (BUILD_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (kind_e'(s_axis_tuser[1:0])),
    .in_key_i    (s_axis_tdata[63:0]),
    .in_null_i   (s_axis_tuser[2]),
    .in_row_i    (s_axis_tdata[79:64]),
    .out_free_i  (out_free),
    .push_o      (push),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_q <= push.res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.store_overflowed, out_q.match_build_index,
                          out_q.match_probe_row};
  assign m_axis_tlast  = out_q.last_match;

`ifndef SYNTHESIS
  // The control must never overwrite a result that the receiver has not taken.
  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> out_free)
    else $error("result pushed into a full output register");

  // Results are only produced while a probe is in progress.
  a_push_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !s_axis_tready)
    else $error("result pushed while the block is idle");

  // A non-final result always has a held match behind it, so the probe is still running.
  a_open_probe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("probe ended without a final result");
`endif

endmodule

// ===== verif/tb_nested_loop_equi_join_probe_top.sv =====
// Self-checking testbench for the nested-loop equi-join probe top level.
// Drives clear, build and probe beats and checks every match beat against an
// in-bench model of the key store. Depends on nlej_pkg and the design files.
module tb_nested_loop_equi_join_probe_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nlej_pkg::*;

  localparam int unsigned BuildDepth = 64;
  localparam int          NumDirected = 16;
  localparam int          NumRandom   = 480;
  localparam int          HoldCycles  = 600;

  localparam logic [63:0] KeyMin  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KeyMax  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KeyOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    kind_e       kind;
    logic [63:0] key;
    bit          nul;
    logic [15:0] row;
    int          exp_n;  // -1: ask the model, otherwise 0 or 1 typed beats
    result_t     exp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Model of the key store.
  logic [63:0] key_mem [BuildDepth];
  int unsigned key_count;
  bit          overflow_seen;
  result_t     pending_matches [$];

  int mismatches;
  int items_sent;
  int send_idle;
  int recv_stall;
  bit hold_req;

  dir_row_t dir_table [NumDirected] = '{
    '{KIND_PROBE, 64'd0,   1'b0, 16'h0000, 0, '0},
    '{KIND_BUILD, KeyMin,  1'b0, 16'h0000, 0, '0},
    '{KIND_BUILD, KeyMax,  1'b0, 16'h0000, 0, '0},
    '{KIND_BUILD, 64'd5,   1'b1, 16'h0000, 0, '0},
    '{KIND_PROBE, KeyMin,  1'b0, 16'hFFFF, 1, '{1'b0, 1'b1, 6'd0, 16'hFFFF}},
    '{KIND_PROBE, KeyMax,  1'b0, 16'h0000, 1, '{1'b0, 1'b1, 6'd1, 16'h0000}},
    '{KIND_PROBE, KeyMin,  1'b1, 16'h0007, 0, '0},
    '{KIND_PROBE, 64'd5,   1'b0, 16'h0008, 0, '0},
    '{KIND_NONE,  KeyMin,  1'b0, 16'h0009, 0, '0},
    '{KIND_BUILD, KeyMin,  1'b0, 16'h0000, 0, '0},
    '{KIND_PROBE, KeyMin,  1'b0, 16'h1234, -1, '0},
    '{KIND_BUILD, KeyOnes, 1'b0, 16'h0000, 0, '0},
    '{KIND_PROBE, KeyOnes, 1'b0, 16'h5555, 1, '{1'b0, 1'b1, 6'd3, 16'h5555}},
    '{KIND_PROBE, KeyMax - 64'd1, 1'b0, 16'hAAAA, 0, '0},
    '{KIND_CLEAR, 64'd0,   1'b0, 16'h0000, 0, '0},
    '{KIND_PROBE, KeyMin,  1'b0, 16'h0001, 0, '0}
  };

  nested_loop_equi_join_probe_top #(
    .BUILD_DEPTH(BuildDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void predict_matches(kind_e kind, logic [63:0] key, bit nul,
                                          logic [15:0] row);
    int      hits;
    result_t r;
    hits = 0;
    case (kind)
      KIND_CLEAR: begin
        key_count     = 0;
        overflow_seen = 1'b0;
      end
      KIND_BUILD: begin
        if (!nul) begin
          if (key_count >= BuildDepth) begin
            overflow_seen = 1'b1;
          end else begin
            key_mem[key_count] = key;
            key_count++;
          end
        end
      end
      KIND_PROBE: begin
        if (!nul) begin
          for (int i = 0; i < int'(key_count); i++) begin
            if (key_mem[i] == key) begin
              r.match_probe_row   = row;
              r.match_build_index = i[5:0];
              r.last_match        = 1'b0;
              r.store_overflowed  = overflow_seen;
              pending_matches.insert(pending_matches.size(), r);
              hits++;
            end
          end
          if (hits > 0) pending_matches[pending_matches.size()-1].last_match = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // One input beat; a typed expectation, where given, replaces the model's.
  task automatic send_item(kind_e kind, logic [63:0] key, bit nul, logic [15:0] row,
                           int exp_n, result_t exp);
    int base;
    @(negedge clk_i);
    while (send_idle > 0 && $urandom_range(1, 100) <= send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, key};
    s_axis_tuser  <= {nul, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    base = pending_matches.size();
    predict_matches(kind, key, nul, row);
    if (exp_n >= 0) begin
      while (pending_matches.size() > base) void'(pending_matches.pop_back());
      if (exp_n == 1) pending_matches.insert(pending_matches.size(), exp);
    end
    if (kind != KIND_NONE) items_sent++;
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 5))
      0: return KeyMin;
      1: return KeyMax;
      2: return 64'd0;
      3: return KeyOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A build-then-probe sequence over a small pool of keys, so that probes hit.
  task automatic run_sequence(bit dense);
    logic [63:0] pool [6];
    logic [63:0] key;
    int          pool_n;
    int          n_build;
    int          n_probe;
    pool_n = dense ? $urandom_range(1, 2) : $urandom_range(1, 6);
    for (int i = 0; i < pool_n; i++) pool[i] = pick_key();
    if (dense || $urandom_range(0, 9) < 8) begin
      send_item(KIND_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)), 16'($urandom),
                -1, '0);
    end
    n_build = (dense || $urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 12);
    for (int i = 0; i < n_build; i++) begin
      key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : pool[$urandom_range(0, pool_n-1)];
      send_item(KIND_BUILD, key, $urandom_range(0, 12) == 0, 16'($urandom), -1, '0);
    end
    n_probe = $urandom_range(2, 8);
    for (int i = 0; i < n_probe; i++) begin
      key = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                        : pool[$urandom_range(0, pool_n-1)];
      send_item(KIND_PROBE, key, $urandom_range(0, 12) == 0, 16'($urandom), -1, '0);
    end
  endtask

  task automatic run_noise();
    for (int i = 0; i < 6; i++) begin
      send_item(kind_e'($urandom_range(0, 3)), {$urandom, $urandom},
                1'($urandom_range(0, 1)), 16'($urandom), -1, '0);
    end
  endtask

  task automatic note_mismatch(result_t exp, logic [23:0] data, logic last);
    mismatches++;
    if (mismatches <= 10) begin
      $display({"%0t: match beat differs: exp row %h idx %0d last %b ovf %b, ",
                "got row %h idx %0d last %b ovf %b top %b"},
               $realtime, exp.match_probe_row, exp.match_build_index, exp.last_match,
               exp.store_overflowed, data[15:0], data[21:16], last, data[22], data[23]);
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected match beat, data %h last %b", $realtime, m_axis_tdata,
                   m_axis_tlast);
        end
      end else begin
        exp = pending_matches.pop_front();
        if (m_axis_tdata != {1'b0, exp.store_overflowed, exp.match_build_index,
                             exp.match_probe_row} || m_axis_tlast != exp.last_match) begin
          note_mismatch(exp, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(1, 100) > recv_stall);
    end
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    key_count     = 0;
    overflow_seen = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    send_idle     = 0;
    recv_stall    = 0;
    hold_req      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_item(dir_table[i].kind, dir_table[i].key, dir_table[i].nul, dir_table[i].row,
                dir_table[i].exp_n, dir_table[i].exp);
    end

    // A full store of few distinct keys while the receiver holds off fills the
    // output path and must stall the input side.
    hold_req = 1'b1;
    run_sequence(1'b1);

    while (items_sent < NumDirected + NumRandom) begin
      phase = (items_sent - NumDirected) * 4 / NumRandom;
      case (phase)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 72; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 72; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      if ($urandom_range(0, 7) == 0) run_noise();
      else run_sequence($urandom_range(0, 11) == 0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    recv_stall = 0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
